[rtl/chts_pkg.sv]
// ----------------------------------------------------------------------------
// chts_pkg
// Types, constants and helper functions shared by the history table search
// block and its storage cells.
// ----------------------------------------------------------------------------
package chts_pkg;

  // Number of records held in the table (2 to 64).
  localparam int TABLE_DEPTH = 64;
  localparam int SLOT_W      = 6;
  localparam int COUNT_W     = 7;
  localparam int FILL_W      = $clog2(TABLE_DEPTH + 1);
  localparam int SCAN_W      = $clog2(TABLE_DEPTH);
  localparam int DATE_W      = 20;
  localparam int KEY_W       = 64;
  localparam int PROC_W      = 4;
  localparam int MODE_W      = 3;
  localparam int CFG_IDX_W   = 3;

  localparam logic [DATE_W-1:0] DATE_MAX = '1;

  // Operation codes carried by a command.
  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_SEARCH = 2'd3
  } op_t;

  // Search mode codes.
  localparam logic [MODE_W-1:0] MODE_DATE    = 3'd0;
  localparam logic [MODE_W-1:0] MODE_PROC    = 3'd1;
  localparam logic [MODE_W-1:0] MODE_TEST    = 3'd2;
  localparam logic [MODE_W-1:0] MODE_USER    = 3'd3;
  localparam logic [MODE_W-1:0] MODE_PATIENT = 3'd4;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_SEARCH_MODE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DATE_FIRST  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DATE_LAST   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_QUERY_PROC  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_QUERY_KEY   = 3'd4;

  typedef struct packed {
    op_t          operation;
    logic [5:0]   slot_index;
    logic [6:0]   rec_year;
    logic [3:0]   rec_month;
    logic [4:0]   rec_day;
    logic [3:0]   rec_procedure;
    logic [63:0]  rec_test_name;
    logic [63:0]  rec_user_name;
    logic [63:0]  rec_patient_id;
  } cmd_t;

  typedef struct packed {
    logic [5:0]   out_slot;
    logic         slot_valid;
    logic         evicted_oldest;
    logic         bad_index;
    logic [6:0]   match_count;
    logic         last_result;
  } result_t;

  // One stored record.
  typedef struct packed {
    logic              valid;
    logic [DATE_W-1:0] date;
    logic [PROC_W-1:0] procedure;
    logic [KEY_W-1:0]  test_key;
    logic [KEY_W-1:0]  user_key;
    logic [KEY_W-1:0]  patient_key;
  } entry_t;

  // Search settings seen by every cell.
  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [DATE_W-1:0] date_first;
    logic [DATE_W-1:0] date_last;
    logic [PROC_W-1:0] procedure;
    logic [KEY_W-1:0]  key;
  } query_t;

  // Per-cell control from the sequencer.
  typedef struct packed {
    logic clear;
    logic write;
    logic shift;
    logic load_hit;
    logic shift_hit;
  } cell_ctl_t;

  // True when a stored record satisfies the current search settings.
  function automatic logic record_matches(entry_t e, query_t q);
    logic m;
    m = 1'b0;
    unique case (q.mode)
      MODE_DATE:    m = (e.date == q.date_first) || (e.date == q.date_last) ||
                        ((e.date > q.date_first) && (e.date < q.date_last));
      MODE_PROC:    m = (e.procedure == q.procedure);
      MODE_TEST:    m = (e.test_key == q.key);
      MODE_USER:    m = (e.user_key == q.key);
      MODE_PATIENT: m = (e.patient_key == q.key);
      default:      m = 1'b0;
    endcase
    return m;
  endfunction

  // Packs a date as year*10000 + month*100 + day, saturating at 20 bits.
  function automatic logic [DATE_W-1:0] pack_date(logic [6:0] y, logic [3:0] m,
                                                  logic [4:0] d);
    logic [22:0] sum;
    sum = 23'(y) * 23'd10000 + 23'(m) * 23'd100 + 23'(d);
    return (sum > 23'(DATE_MAX)) ? DATE_MAX : sum[DATE_W-1:0];
  endfunction

endpackage

[rtl/compacting_history_table_search.sv]
// ----------------------------------------------------------------------------
// compacting_history_table_search
// Compacting record table with insert, delete, clear and a top-down search.
// ----------------------------------------------------------------------------
// Insert, delete and clear give their single result, registered, on the cycle
// after start, and busy stays low. A search steps the hit flags one slot a
// cycle up the chain of cells; busy is high while it runs, and matches appear
// top slot first, at most one per cycle, each on the result port for one cycle
// with result_valid. Results cannot be held off, so the receiver must take
// every one. Configuration writes are always ready and take effect at once.
module compacting_history_table_search
  import chts_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  cmd_t                 cmd,
  output logic                 result_valid,
  output result_t              result,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0]          cfg_data
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FLUSH
  } state_t;

  state_t             state;
  logic [FILL_W-1:0]  fill;
  logic [SCAN_W-1:0]  scan;
  logic [COUNT_W-1:0] count;
  logic               pend;
  logic [SLOT_W-1:0]  pend_slot;
  logic [COUNT_W-1:0] pend_count;
  query_t             query;

  state_t             state_next;
  logic [FILL_W-1:0]  fill_next;
  logic [SCAN_W-1:0]  scan_next;
  logic [COUNT_W-1:0] count_next;
  logic               pend_next;
  logic [SLOT_W-1:0]  pend_slot_next;
  logic [COUNT_W-1:0] pend_count_next;
  logic               result_valid_next;
  result_t            result_next;

  entry_t    entries [TABLE_DEPTH];
  logic      hits    [TABLE_DEPTH];
  cell_ctl_t ctls    [TABLE_DEPTH];

  logic              accept;
  logic              full;
  logic              bad;
  logic              do_insert;
  logic              do_delete;
  logic              do_clear;
  logic              do_search;
  entry_t            new_record;
  logic [SLOT_W-1:0] scan_slot;
  logic [COUNT_W-1:0] count_inc;

  assign cfg_ready = 1'b1;
  assign busy      = (state != ST_IDLE);
  assign accept    = start && !busy;
  assign full      = (fill == FILL_W'(TABLE_DEPTH));
  assign bad       = ({1'b0, cmd.slot_index} >= 7'(TABLE_DEPTH));
  assign do_insert = accept && (cmd.operation == OP_INSERT);
  assign do_delete = accept && (cmd.operation == OP_DELETE) && !bad;
  assign do_clear  = accept && (cmd.operation == OP_CLEAR);
  assign do_search = accept && (cmd.operation == OP_SEARCH);
  assign scan_slot = SLOT_W'(TABLE_DEPTH - 1) - SLOT_W'(scan);
  assign count_inc = (count < COUNT_W'(TABLE_DEPTH)) ? count + 1'b1 : count;

  // Record built from the command fields.
  always_comb begin
    new_record.valid       = 1'b1;
    new_record.date        = pack_date(cmd.rec_year, cmd.rec_month, cmd.rec_day);
    new_record.procedure   = cmd.rec_procedure;
    new_record.test_key    = cmd.rec_test_name;
    new_record.user_key    = cmd.rec_user_name;
    new_record.patient_key = cmd.rec_patient_id;
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      query <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_SEARCH_MODE: query.mode       <= cfg_data[MODE_W-1:0];
        CFG_DATE_FIRST:  query.date_first <= cfg_data[DATE_W-1:0];
        CFG_DATE_LAST:   query.date_last  <= cfg_data[DATE_W-1:0];
        CFG_QUERY_PROC:  query.procedure  <= cfg_data[PROC_W-1:0];
        CFG_QUERY_KEY:   query.key        <= cfg_data;
        default:         ;
      endcase
    end
  end

  // Chain of cells with per-slot control.
  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    always_comb begin
      ctls[i].clear     = do_clear;
      ctls[i].write     = do_insert &&
                          (full ? (i == TABLE_DEPTH - 1) : (fill == FILL_W'(i)));
      ctls[i].shift     = (do_insert && full) ||
                          (do_delete && (7'(i) >= {1'b0, cmd.slot_index}));
      ctls[i].load_hit  = do_search;
      ctls[i].shift_hit = (state == ST_SCAN);
    end

    chts_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctl       (ctls[i]),
      .record    (new_record),
      .upper     ((i == TABLE_DEPTH - 1) ? entry_t'('0) : entries[(i + 1) % TABLE_DEPTH]),
      .lower_hit ((i == 0) ? 1'b0 : hits[(i + TABLE_DEPTH - 1) % TABLE_DEPTH]),
      .query     (query),
      .entry     (entries[i]),
      .hit       (hits[i])
    );
  end

  // Sequencer next state, fill count and result.
  always_comb begin
    state_next        = state;
    fill_next         = fill;
    scan_next         = scan;
    count_next        = count;
    pend_next         = pend;
    pend_slot_next    = pend_slot;
    pend_count_next   = pend_count;
    result_valid_next = 1'b0;
    result_next       = '0;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          result_valid_next       = 1'b1;
          result_next.last_result = 1'b1;
          unique case (cmd.operation)
            OP_INSERT: begin
              result_next.slot_valid     = 1'b1;
              result_next.evicted_oldest = full;
              result_next.out_slot       = full ? SLOT_W'(TABLE_DEPTH - 1) : SLOT_W'(fill);
              if (!full) begin
                fill_next = fill + 1'b1;
              end
            end
            OP_DELETE: begin
              if (bad) begin
                result_next.bad_index = 1'b1;
              end else begin
                result_next.slot_valid = 1'b1;
                result_next.out_slot   = cmd.slot_index;
                if ({1'b0, cmd.slot_index} < 7'(fill)) begin
                  fill_next = fill - 1'b1;
                end
              end
            end
            OP_CLEAR: begin
              fill_next = '0;
            end
            OP_SEARCH: begin
              result_valid_next = 1'b0;
              state_next        = ST_SCAN;
              scan_next         = '0;
              count_next        = '0;
              pend_next         = 1'b0;
            end
            default: ;
          endcase
        end
      end
      ST_SCAN: begin
        // The top cell holds the hit for the slot under scan.
        if (hits[TABLE_DEPTH - 1]) begin
          count_next      = count_inc;
          pend_next       = 1'b1;
          pend_slot_next  = scan_slot;
          pend_count_next = count_inc;
          if (pend) begin
            result_valid_next       = 1'b1;
            result_next.out_slot    = pend_slot;
            result_next.slot_valid  = 1'b1;
            result_next.match_count = pend_count;
          end
        end
        if (scan == SCAN_W'(TABLE_DEPTH - 1)) begin
          state_next = ST_FLUSH;
        end else begin
          scan_next = scan + 1'b1;
        end
      end
      ST_FLUSH: begin
        result_valid_next       = 1'b1;
        result_next.last_result = 1'b1;
        if (pend) begin
          result_next.out_slot    = pend_slot;
          result_next.slot_valid  = 1'b1;
          result_next.match_count = pend_count;
        end
        pend_next  = 1'b0;
        state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Sequencer state and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      fill         <= '0;
      scan         <= '0;
      count        <= '0;
      pend         <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      fill         <= fill_next;
      scan         <= scan_next;
      count        <= count_next;
      pend         <= pend_next;
      pend_slot    <= pend_slot_next;
      pend_count   <= pend_count_next;
      result_valid <= result_valid_next;
      result       <= result_next;
    end
  end

`ifndef SYNTHESIS
  // A command other than search answers with a single final result on the next cycle.
  a_single_result: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (cmd.operation != OP_SEARCH)) |=>
      (result_valid && result.last_result && !busy))
    else $error("one-cycle command did not produce a final result");

  // The fill count never passes the table depth.
  a_fill_range: assert property (@(posedge clk) disable iff (rst)
    fill <= FILL_W'(TABLE_DEPTH))
    else $error("fill count above table depth");

  // A search result with a nonzero count always carries a real slot.
  a_count_slot: assert property (@(posedge clk) disable iff (rst)
    (result_valid && (result.match_count != '0)) |-> result.slot_valid)
    else $error("match count without a slot");

  // No result leaves while the scan has found nothing yet.
  a_scan_quiet: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_SCAN) && !pend) |=> !result_valid)
    else $error("result during scan before any match");
`endif

endmodule

[rtl/chts_cell.sv]
// ----------------------------------------------------------------------------
// chts_cell
// One table slot: holds a record, takes its upper neighbor's record when the
// table compacts, and passes its search hit flag up the chain during a scan.
// ----------------------------------------------------------------------------
module chts_cell
  import chts_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  cell_ctl_t ctl,
  input  entry_t    record,
  input  entry_t    upper,
  input  logic      lower_hit,
  input  query_t    query,
  output entry_t    entry,
  output logic      hit
);

  // Record storage; only the valid mark is reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      entry.valid <= 1'b0;
    end else if (ctl.clear) begin
      entry.valid <= 1'b0;
    end else if (ctl.write) begin
      entry <= record;
    end else if (ctl.shift) begin
      entry <= upper;
    end
  end

  // Hit flag: evaluated locally at search start, then moved up the chain.
  always_ff @(posedge clk) begin
    if (rst) begin
      hit <= 1'b0;
    end else if (ctl.load_hit) begin
      hit <= entry.valid && record_matches(entry, query);
    end else if (ctl.shift_hit) begin
      hit <= lower_hit;
    end
  end

endmodule
